/* src/satl_pkg.sv */
package satl_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int COUNT_W     = 32;
  localparam int LFSR_W      = 16;
  localparam int WAY_IDX_W   = 4;
  localparam int WAY_OUT_W   = 2;

  localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 free;
    logic [WAY_IDX_W-1:0] free_way;
  } probe_t;

  function automatic int floor_log2(input int v);
    int b;
    int x;
    b = 0;
    x = v;
    for (int i = 0; i < 31; i++) begin
      if (x > 1) begin
        x = x >>> 1;
        b = b + 1;
      end
    end
    return b;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    return {s[0] ^ s[2] ^ s[3] ^ s[5], s[LFSR_W-1:1]};
  endfunction

endpackage

/* src/satl_ram.sv */
module satl_ram #(
  parameter int WIDTH = 76,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/satl_probe.sv */
module satl_probe #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 18
) (
  input  logic [WAYS*TAG_W-1:0] row_tags,
  input  logic [WAYS-1:0]       row_valid,
  input  logic [TAG_W-1:0]      tag,
  output satl_pkg::probe_t      probe
);

  always_comb begin
    probe = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_valid[w] && (row_tags[w*TAG_W +: TAG_W] == tag)) begin
        probe.hit     = 1'b1;
        probe.hit_way = satl_pkg::WAY_IDX_W'(w);
      end
      if (!row_valid[w]) begin
        probe.free     = 1'b1;
        probe.free_way = satl_pkg::WAY_IDX_W'(w);
      end
    end
  end

endmodule

/* src/satl_victim.sv */
module satl_victim #(
  parameter int WAYS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] victim_way
);

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SUM_W = WAY_W + 2;

  logic [satl_pkg::LFSR_W-1:0] lfsr;
  logic [satl_pkg::LFSR_W-1:0] lfsr_next;
  logic [WAY_W-1:0]            res_tab [4][16];
  logic [SUM_W-1:0]            res_sum;
  logic [SUM_W-1:0]            res_half;

  for (genvar k = 0; k < 4; k++) begin : g_pos
    for (genvar n = 0; n < 16; n++) begin : g_dig
      localparam int Res = (n * (1 << (4 * k))) % WAYS;
      assign res_tab[k][n] = WAY_W'(Res);
    end
  end

  assign lfsr_next = satl_pkg::lfsr_next(lfsr);

  always_comb begin
    res_sum = SUM_W'(res_tab[0][lfsr_next[3:0]]) + SUM_W'(res_tab[1][lfsr_next[7:4]])
            + SUM_W'(res_tab[2][lfsr_next[11:8]]) + SUM_W'(res_tab[3][lfsr_next[15:12]]);
    res_half = (res_sum >= SUM_W'(2 * WAYS)) ? res_sum - SUM_W'(2 * WAYS) : res_sum;
    victim_way = (res_half >= SUM_W'(WAYS)) ? WAY_W'(res_half - SUM_W'(WAYS))
                                            : WAY_W'(res_half);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= satl_pkg::LFSR_SEED;
    end else if (advance) begin
      lfsr <= lfsr_next;
    end
  end

endmodule

/* src/set_assoc_cache_tag_lookup_core.sv */
// An accepted address enters the lookup stage, where its row comes from a registered RAM read;
// the probe result is then registered for the master side. Throughput: one address per cycle
// unless the output stalls; tag and valid rows sit in one RAM, written back on a miss as the word
// moves on, with the row forwarded to a same-set successor. Reset: counters clear, the replacement
// LFSR loads 0xACE1, then a sweep clears every row, one row a cycle, with s_tready held low throughout.
module set_assoc_cache_tag_lookup_core #(
  parameter int WAYS         = 4,
  parameter int LINE_BYTES   = 16,
  parameter int CACHE_BYTES  = 65536,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [satl_pkg::IN_TDATA_W-1:0]     s_tdata,  // address[31:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [satl_pkg::OUT_TDATA_W-1:0]    m_tdata   // hit, way_used[1:0], hit_count[31:0],
                                                        // miss_count[31:0], zero pad[4:0]
);

  localparam int SETS     = CACHE_BYTES / (WAYS * LINE_BYTES);
  localparam int OFF_BITS = satl_pkg::floor_log2(LINE_BYTES);
  localparam int IDX_BITS = satl_pkg::floor_log2(SETS);
  localparam int NSETS    = 1 << IDX_BITS;
  localparam int SET_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int SHIFT    = OFF_BITS + IDX_BITS;
  localparam int TAG_LEN  = (ADDRESS_BITS > SHIFT) ? ADDRESS_BITS - SHIFT : 0;
  localparam int TAG_W    = (TAG_LEN > 0) ? TAG_LEN : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAGS_W   = WAYS * TAG_W;
  localparam int ROW_W    = TAGS_W + WAYS;
  localparam int PAD_W    = satl_pkg::OUT_TDATA_W - 1 - satl_pkg::WAY_OUT_W
                          - 2 * satl_pkg::COUNT_W;

  logic [31:0]      addr;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;
  logic             accept;
  logic             st_adv;

  logic             clearing;
  logic [SET_W-1:0] clr_idx;

  logic             st_valid;
  logic [SET_W-1:0] st_set;
  logic [TAG_W-1:0] st_tag;
  logic             st_fwd;
  logic [ROW_W-1:0] st_fwd_row;

  logic [ROW_W-1:0] ram_rd;
  logic [ROW_W-1:0] cur_row;
  logic [ROW_W-1:0] new_row;
  logic             ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;

  satl_pkg::probe_t probe;
  logic [WAY_W-1:0] victim_way;
  logic [WAY_W-1:0] way_sel;
  logic             fill;
  logic             evict;

  logic [satl_pkg::COUNT_W-1:0]   hits_total;
  logic [satl_pkg::COUNT_W-1:0]   misses_total;
  logic                           out_hit;
  logic [satl_pkg::WAY_OUT_W-1:0] out_way;

  assign addr   = 32'({1'b0, s_tdata} & ((33'd1 << ADDRESS_BITS) - 33'd1));
  assign in_set = (IDX_BITS > 0) ? SET_W'(addr >> OFF_BITS) : '0;
  assign in_tag = TAG_W'(addr >> SHIFT);

  assign st_adv   = !m_tvalid || m_tready;
  assign s_tready = !clearing && (!st_valid || st_adv);
  assign accept   = s_tvalid && s_tready;

  assign cur_row = st_fwd ? st_fwd_row : ram_rd;

  satl_probe #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W)
  ) u_probe (
    .row_tags  (cur_row[TAGS_W-1:0]),
    .row_valid (cur_row[ROW_W-1:TAGS_W]),
    .tag       (st_tag),
    .probe     (probe)
  );

  assign fill  = st_valid && st_adv && !probe.hit;
  assign evict = fill && !probe.free;

  satl_victim #(
    .WAYS (WAYS)
  ) u_victim (
    .clk        (clk),
    .rst        (rst),
    .advance    (evict),
    .victim_way (victim_way)
  );

  always_comb begin
    if (probe.hit) begin
      way_sel = WAY_W'(probe.hit_way);
    end else if (probe.free) begin
      way_sel = WAY_W'(probe.free_way);
    end else begin
      way_sel = victim_way;
    end
    new_row = cur_row;
    for (int w = 0; w < WAYS; w++) begin
      if (way_sel == WAY_W'(w)) begin
        new_row[w*TAG_W +: TAG_W] = st_tag;
        new_row[TAGS_W + w]       = 1'b1;
      end
    end
  end

  assign ram_wr_en   = clearing || fill;
  assign ram_wr_addr = clearing ? clr_idx : st_set;
  assign ram_wr_data = clearing ? '0 : new_row;

  satl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NSETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_idx      <= '0;
      st_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      hits_total   <= '0;
      misses_total <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + SET_W'(1);
        if (clr_idx == SET_W'(NSETS - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        st_valid <= 1'b1;
      end else if (st_adv) begin
        st_valid <= 1'b0;
      end
      if (st_valid && st_adv) begin
        m_tvalid <= 1'b1;
        if (probe.hit) begin
          if (hits_total != satl_pkg::COUNT_MAX) begin
            hits_total <= hits_total + satl_pkg::COUNT_W'(1);
          end
        end else if (misses_total != satl_pkg::COUNT_MAX) begin
          misses_total <= misses_total + satl_pkg::COUNT_W'(1);
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_set     <= in_set;
      st_tag     <= in_tag;
      st_fwd     <= fill && (st_set == in_set);
      st_fwd_row <= new_row;
    end
    if (st_valid && st_adv) begin
      out_hit <= probe.hit;
      out_way <= satl_pkg::WAY_OUT_W'(way_sel);
    end
  end

  assign m_tdata = {PAD_W'(0), misses_total, hits_total, out_way, out_hit};

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> ($countones({hits_total != $past(hits_total),
                               misses_total != $past(misses_total)}) <= 1))
    else $error("both counters moved in one cycle");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_idx) == SET_W'(NSETS - 1)))
    else $error("row sweep ended early");

  a_victim_range: assert property (@(posedge clk) disable iff (rst)
    evict |-> (int'(victim_way) < WAYS))
    else $error("victim way out of range");

endmodule

/* verif/testbench.sv */
module testbench;

  localparam int WAYS       = 4;
  localparam int SETS       = 1024;
  localparam int OFF_BITS   = 4;
  localparam int IDX_BITS   = 10;
  localparam int TAG_LEN    = 18;
  localparam int HALF       = 10;
  localparam int LIMIT      = 400000;
  localparam int RAND_ITEMS = 1800;
  localparam int POOL       = 6;

  typedef struct {
    bit                            hit;
    bit [satl_pkg::WAY_OUT_W-1:0]  way;
    bit [satl_pkg::COUNT_W-1:0]    hits;
    bit [satl_pkg::COUNT_W-1:0]    misses;
  } lookup_t;

  class lookup_scoreboard;
    bit                         valid_row [SETS][WAYS];
    bit [TAG_LEN-1:0]           tag_row   [SETS][WAYS];
    bit [satl_pkg::COUNT_W-1:0] hits_seen;
    bit [satl_pkg::COUNT_W-1:0] misses_seen;
    bit [satl_pkg::LFSR_W-1:0]  victim_sr = satl_pkg::LFSR_SEED;
    lookup_t                    pending_q[$];
    int                         errors;

    function void note_address(bit [31:0] addr);
      lookup_t           r;
      bit [IDX_BITS-1:0] set;
      bit [TAG_LEN-1:0]  tag;
      bit                found;
      bit                fb;
      int                w;
      set   = addr[OFF_BITS +: IDX_BITS];
      tag   = addr[31 -: TAG_LEN];
      found = 1'b0;
      w     = 0;
      for (int i = 0; i < WAYS; i++) begin
        if (!found && valid_row[set][i] && tag_row[set][i] == tag) begin
          found = 1'b1;
          w     = i;
        end
      end
      if (found) begin
        if (hits_seen != satl_pkg::COUNT_MAX) hits_seen++;
      end else begin
        w = -1;
        for (int i = WAYS - 1; i >= 0; i--) begin
          if (!valid_row[set][i]) w = i;
        end
        if (w < 0) begin
          fb        = ^(victim_sr & 16'h002D);
          victim_sr = {fb, victim_sr[15:1]};
          w         = victim_sr % WAYS;
        end
        tag_row[set][w]   = tag;
        valid_row[set][w] = 1'b1;
        if (misses_seen != satl_pkg::COUNT_MAX) misses_seen++;
      end
      r.hit    = found;
      r.way    = w[satl_pkg::WAY_OUT_W-1:0];
      r.hits   = hits_seen;
      r.misses = misses_seen;
      pending_q.push_back(r);
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_word(bit [satl_pkg::OUT_TDATA_W-1:0] word);
      lookup_t r;
      if (pending_q.size() == 0) begin
        report("unexpected word", 0, word[63:0]);
        return;
      end
      r = pending_q.pop_front();
      if (word[0] != r.hit) report("hit", r.hit, word[0]);
      if (word[2:1] != r.way) report("way_used", r.way, word[2:1]);
      if (word[34:3] != r.hits) report("hit_count", r.hits, word[34:3]);
      if (word[66:35] != r.misses) report("miss_count", r.misses, word[66:35]);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [satl_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [satl_pkg::OUT_TDATA_W-1:0]   m_tdata;

  lookup_scoreboard sb = new;
  bit [31:0]        addr_q[$];
  int               stall_mode;
  int               stall_run;

  set_assoc_cache_tag_lookup_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #HALF clk = ~clk;

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(8, 64);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= (stall_run[3:2] != 2'b00);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic bit [31:0] line_addr(bit [TAG_LEN-1:0] tag, bit [IDX_BITS-1:0] set,
                                          bit [OFF_BITS-1:0] off);
    return {tag, set, off};
  endfunction

  task automatic send_word(input bit [31:0] addr);
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_address(addr);
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic build_directed();
    addr_q.push_back(32'h0000_0000);
    addr_q.push_back(32'h0000_0000);
    addr_q.push_back(32'h0000_000F);
    addr_q.push_back(32'hFFFF_FFFF);
    addr_q.push_back(32'hFFFF_FFF0);
    for (int t = 1; t <= 4; t++)
      addr_q.push_back(line_addr(TAG_LEN'(t), IDX_BITS'(5), OFF_BITS'(t)));
    for (int t = 4; t >= 1; t--)
      addr_q.push_back(line_addr(TAG_LEN'(t), IDX_BITS'(5), OFF_BITS'(0)));
    for (int t = 5; t <= 8; t++)
      addr_q.push_back(line_addr(TAG_LEN'(t), IDX_BITS'(5), OFF_BITS'(15)));
    addr_q.push_back(line_addr(TAG_LEN'(1), IDX_BITS'(5), OFF_BITS'(0)));
    addr_q.push_back(32'hFFFF_C000);
    addr_q.push_back(32'h0000_3FF0);
    addr_q.push_back(32'h8000_0000);
    addr_q.push_back(32'h0000_3FF0);
    addr_q.push_back(32'h5555_5555);
    addr_q.push_back(32'hAAAA_AAAA);
  endtask

  task automatic build_random();
    bit [IDX_BITS-1:0] set_pool[POOL];
    bit [TAG_LEN-1:0]  tag_pool[POOL];
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 300 == 0) begin
        for (int i = 0; i < POOL; i++) begin
          set_pool[i] = IDX_BITS'($urandom);
          tag_pool[i] = TAG_LEN'($urandom);
        end
        tag_pool[0] = '0;
        tag_pool[1] = '1;
      end
      if ($urandom_range(0, 3) == 0)
        addr_q.push_back($urandom);
      else
        addr_q.push_back(line_addr(tag_pool[$urandom_range(0, POOL - 1)],
                                   set_pool[$urandom_range(0, POOL - 1)],
                                   OFF_BITS'($urandom)));
    end
  endtask

  initial begin
    int burst;
    int drain;
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    burst = 0;
    while (addr_q.size() != 0) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        idle_for($urandom_range(0, 6));
      end
      send_word(addr_q.pop_front());
      burst--;
    end
    idle_for(1);
    while (sb.pending() != 0) @(posedge clk);
    drain = 0;
    while (drain < 8) begin
      @(posedge clk);
      drain++;
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/satl_pkg.sv
src/satl_ram.sv
src/satl_probe.sv
src/satl_victim.sv
src/set_assoc_cache_tag_lookup_core.sv
verif/testbench.sv
